FILE: src/bls_pkg.sv
// Shared types, codes and constants for the Bresenham line stepper.
// Used by every module of the block; no dependencies of its own.
`default_nettype none

package bls_pkg;

  // Fixed field widths
  localparam int REG_W          = 12;
  localparam int ADDR_W         = 22;
  localparam int CFG_IDX_W      = 2;

  // Parameter defaults
  localparam int COORD_BITS_DEF = 12;
  localparam int FIFO_DEPTH_DEF = 2;

  // Register reset values
  localparam logic [REG_W-1:0] FRAME_WIDTH_RST  = 12'd1024;
  localparam logic [REG_W-1:0] FRAME_HEIGHT_RST = 12'd768;

  // Item kinds carried on the input tuser
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } reg_idx_e;

  // Bits of one queued command: kind, four endpoints, two deltas,
  // two direction flags, step total and error term.
  function automatic int cmd_width(int coord_bits);
    return 8 * coord_bits + 5;
  endfunction

endpackage

`default_nettype wire

FILE: src/bls_front.sv
// Front end: accepts input beats, classifies them and does the line setup.
// Depends on bls_pkg; feeds the command queue.
`default_nettype none

module bls_front #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF,
  parameter int CMD_W      = bls_pkg::cmd_width(COORD_BITS)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire bls_pkg::action_e      action_i,
  input  wire logic [COORD_BITS-1:0] start_x_i,
  input  wire logic [COORD_BITS-1:0] start_y_i,
  input  wire logic [COORD_BITS-1:0] end_x_i,
  input  wire logic [COORD_BITS-1:0] end_y_i,
  output logic                       cmd_valid_o,
  input  wire logic                  cmd_ready_i,
  output logic [CMD_W-1:0]           cmd_data_o
);

  localparam int C = COORD_BITS;

  typedef struct packed {
    bls_pkg::action_e action;
    logic [C-1:0]     sx;
    logic [C-1:0]     sy;
    logic [C-1:0]     ex;
    logic [C-1:0]     ey;
    logic [C-1:0]     adx;
    logic [C-1:0]     ady;
    logic             dxn;
    logic             dyn;
    logic [C-1:0]     total;
    logic [C+1:0]     err;
  } cmd_t;

  logic         valid_q;
  cmd_t         cmd_q;
  cmd_t         cmd_d;
  logic         take;
  logic [C:0]   dx;
  logic [C:0]   dy;
  logic [C:0]   adx_full;
  logic [C:0]   ady_full;
  logic [C-1:0] adx;
  logic [C-1:0] ady;

  // Signed deltas, one bit wider than a coordinate
  assign dx = {end_x_i[C-1], end_x_i} - {start_x_i[C-1], start_x_i};
  assign dy = {end_y_i[C-1], end_y_i} - {start_y_i[C-1], start_y_i};

  // Magnitudes always fit in C bits
  assign adx_full = dx[C] ? ((C+1)'(0) - dx) : dx;
  assign ady_full = dy[C] ? ((C+1)'(0) - dy) : dy;
  assign adx      = adx_full[C-1:0];
  assign ady      = ady_full[C-1:0];

  // Build the command record
  always_comb begin
    cmd_d.action = action_i;
    cmd_d.sx     = start_x_i;
    cmd_d.sy     = start_y_i;
    cmd_d.ex     = end_x_i;
    cmd_d.ey     = end_y_i;
    cmd_d.adx    = adx;
    cmd_d.ady    = ady;
    cmd_d.dxn    = !($signed(start_x_i) < $signed(end_x_i));
    cmd_d.dyn    = !($signed(start_y_i) < $signed(end_y_i));
    cmd_d.total  = (adx >= ady) ? adx : ady;
    cmd_d.err    = {2'b00, adx} - {2'b00, ady};
  end

  // Hold one command until the queue takes it
  assign in_ready_o  = !valid_q || cmd_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign cmd_valid_o = valid_q;
  assign cmd_data_o  = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/bls_fifo.sv
// Short command queue between the front end and the step engine.
// Generic width and depth; no package dependencies beyond defaults.
`default_nettype none

module bls_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bls_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [WIDTH-1:0]      pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/bls_engine.sv
// Step engine: holds the active line and advances it one pixel per step.
// Depends on bls_pkg; takes commands from the queue, feeds the address stage.
`default_nettype none

module bls_engine #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF,
  parameter int CMD_W      = bls_pkg::cmd_width(COORD_BITS)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cmd_valid_i,
  output logic                  cmd_ready_o,
  input  wire logic [CMD_W-1:0] cmd_data_i,
  output logic                  pix_valid_o,
  input  wire logic             pix_ready_i,
  output logic [COORD_BITS-1:0] pix_x_o,
  output logic [COORD_BITS-1:0] pix_y_o,
  output logic [COORD_BITS-1:0] pix_index_o,
  output logic [COORD_BITS-1:0] pix_total_o,
  output logic                  pix_last_o
);

  localparam int C = COORD_BITS;

  typedef struct packed {
    bls_pkg::action_e action;
    logic [C-1:0]     sx;
    logic [C-1:0]     sy;
    logic [C-1:0]     ex;
    logic [C-1:0]     ey;
    logic [C-1:0]     adx;
    logic [C-1:0]     ady;
    logic             dxn;
    logic             dyn;
    logic [C-1:0]     total;
    logic [C+1:0]     err;
  } cmd_t;

  cmd_t                cmd;
  logic                active_q;
  logic [C-1:0]        x_q;
  logic [C-1:0]        y_q;
  logic [C-1:0]        tx_q;
  logic [C-1:0]        ty_q;
  logic [C-1:0]        adx_q;
  logic [C-1:0]        ady_q;
  logic                dxn_q;
  logic                dyn_q;
  logic [C+1:0]        err_q;
  logic [C-1:0]        cnt_q;
  logic [C-1:0]        total_q;

  logic                pix_valid_q;
  logic [C-1:0]        pix_x_q;
  logic [C-1:0]        pix_y_q;
  logic [C-1:0]        pix_index_q;
  logic [C-1:0]        pix_total_q;
  logic                pix_last_q;

  logic                is_step;
  logic                pix_free;
  logic                take;
  logic                is_load;
  logic                emit;
  logic signed [C+2:0] e2;
  logic signed [C+2:0] neg_ady;
  logic signed [C+2:0] pos_adx;
  logic                step_x;
  logic                step_y;
  logic [C+1:0]        err_n;
  logic [C-1:0]        x_n;
  logic [C-1:0]        y_n;
  logic                fin;

  assign cmd = cmd_t'(cmd_data_i);

  // Loads and idle steps never wait; a live step waits for a free pixel slot
  assign is_step     = (cmd.action == bls_pkg::ACT_STEP);
  assign pix_free    = !pix_valid_q || pix_ready_i;
  assign cmd_ready_o = !is_step || !active_q || pix_free;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign is_load     = take && !is_step;
  assign emit        = take && is_step && active_q;

  // Bresenham decision on the doubled error term
  assign e2      = $signed({err_q, 1'b0});
  assign neg_ady = -$signed({3'b000, ady_q});
  assign pos_adx = $signed({3'b000, adx_q});
  assign step_x  = (e2 > neg_ady);
  assign step_y  = (e2 < pos_adx);

  always_comb begin
    err_n = err_q;
    if (step_x) begin
      err_n = err_n - {2'b00, ady_q};
    end
    if (step_y) begin
      err_n = err_n + {2'b00, adx_q};
    end
  end

  assign x_n = step_x ? (dxn_q ? x_q - 1'b1 : x_q + 1'b1) : x_q;
  assign y_n = step_y ? (dyn_q ? y_q - 1'b1 : y_q + 1'b1) : y_q;
  assign fin = (x_n == tx_q) && (y_n == ty_q);

  // Line-active flag and pixel slot valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      pix_valid_q <= 1'b0;
    end else begin
      if (is_load) begin
        active_q <= (cmd.sx != cmd.ex) || (cmd.sy != cmd.ey);
      end else if (emit && fin) begin
        active_q <= 1'b0;
      end
      if (emit) begin
        pix_valid_q <= 1'b1;
      end else if (pix_ready_i) begin
        pix_valid_q <= 1'b0;
      end
    end
  end

  // Load a new line or advance the current one
  always_ff @(posedge clk_i) begin
    if (is_load) begin
      x_q     <= cmd.sx;
      y_q     <= cmd.sy;
      tx_q    <= cmd.ex;
      ty_q    <= cmd.ey;
      adx_q   <= cmd.adx;
      ady_q   <= cmd.ady;
      dxn_q   <= cmd.dxn;
      dyn_q   <= cmd.dyn;
      err_q   <= cmd.err;
      cnt_q   <= '0;
      total_q <= cmd.total;
    end else if (emit) begin
      x_q   <= x_n;
      y_q   <= y_n;
      err_q <= err_n;
      cnt_q <= cnt_q + 1'b1;
    end
    if (emit) begin
      pix_x_q     <= x_q;
      pix_y_q     <= y_q;
      pix_index_q <= cnt_q;
      pix_total_q <= total_q;
      pix_last_q  <= fin;
    end
  end

  assign pix_valid_o = pix_valid_q;
  assign pix_x_o     = pix_x_q;
  assign pix_y_o     = pix_y_q;
  assign pix_index_o = pix_index_q;
  assign pix_total_o = pix_total_q;
  assign pix_last_o  = pix_last_q;

endmodule

`default_nettype wire

FILE: src/bls_addr.sv
// Clip and address stage: frame test, row multiply, then the output register.
// Depends on bls_pkg; drives the result channel of the top level.
`default_nettype none

module bls_addr #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [bls_pkg::REG_W-1:0]    frame_width_i,
  input  wire logic [bls_pkg::REG_W-1:0]    frame_height_i,
  input  wire logic                         pix_valid_i,
  output logic                              pix_ready_o,
  input  wire logic [COORD_BITS-1:0]        pix_x_i,
  input  wire logic [COORD_BITS-1:0]        pix_y_i,
  input  wire logic [COORD_BITS-1:0]        pix_index_i,
  input  wire logic [COORD_BITS-1:0]        pix_total_i,
  input  wire logic                         pix_last_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [COORD_BITS-1:0]             pixel_x_o,
  output logic [COORD_BITS-1:0]             pixel_y_o,
  output logic                              inside_res_o,
  output logic [bls_pkg::ADDR_W-1:0]        pixel_address_o,
  output logic [COORD_BITS-1:0]             position_index_o,
  output logic [COORD_BITS-1:0]             total_steps_o,
  output logic                              last_o
);

  localparam int C      = COORD_BITS;
  localparam int RW     = bls_pkg::REG_W;
  localparam int AW     = bls_pkg::ADDR_W;
  localparam int CW     = (C > RW) ? C : RW;
  localparam int PROD_W = C + RW;

  logic              s1_valid_q;
  logic [C-1:0]      s1_x_q;
  logic [C-1:0]      s1_y_q;
  logic [C-1:0]      s1_index_q;
  logic [C-1:0]      s1_total_q;
  logic              s1_last_q;
  logic              s1_inside_q;
  logic [AW-1:0]     s1_prod_q;

  logic              s2_valid_q;
  logic [C-1:0]      s2_x_q;
  logic [C-1:0]      s2_y_q;
  logic [C-1:0]      s2_index_q;
  logic [C-1:0]      s2_total_q;
  logic              s2_last_q;
  logic              s2_inside_q;
  logic [AW-1:0]     s2_addr_q;

  logic              s2_free;
  logic              s1_free;
  logic              in_frame;
  logic [PROD_W-1:0] prod_full;

  assign s2_free     = !s2_valid_q || out_ready_i;
  assign s1_free     = !s1_valid_q || s2_free;
  assign pix_ready_o = s1_free;

  // Frame test and row offset
  assign in_frame = !pix_x_i[C-1] && !pix_y_i[C-1]
                 && (CW'(pix_x_i) < CW'(frame_width_i))
                 && (CW'(pix_y_i) < CW'(frame_height_i));
  assign prod_full = PROD_W'(pix_y_i) * PROD_W'(frame_width_i);

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= pix_valid_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Register product, then add the column and hold the result beat
  always_ff @(posedge clk_i) begin
    if (s1_free && pix_valid_i) begin
      s1_x_q      <= pix_x_i;
      s1_y_q      <= pix_y_i;
      s1_index_q  <= pix_index_i;
      s1_total_q  <= pix_total_i;
      s1_last_q   <= pix_last_i;
      s1_inside_q <= in_frame;
      s1_prod_q   <= AW'(prod_full);
    end
    if (s2_free && s1_valid_q) begin
      s2_x_q      <= s1_x_q;
      s2_y_q      <= s1_y_q;
      s2_index_q  <= s1_index_q;
      s2_total_q  <= s1_total_q;
      s2_last_q   <= s1_last_q;
      s2_inside_q <= s1_inside_q;
      s2_addr_q   <= s1_inside_q ? (AW'(s1_x_q) + s1_prod_q) : '0;
    end
  end

  assign out_valid_o      = s2_valid_q;
  assign pixel_x_o        = s2_x_q;
  assign pixel_y_o        = s2_y_q;
  assign inside_res_o     = s2_inside_q;
  assign pixel_address_o  = s2_addr_q;
  assign position_index_o = s2_index_q;
  assign total_steps_o    = s2_total_q;
  assign last_o           = s2_last_q;

endmodule

`default_nettype wire

FILE: src/bresenham_line_stepper.sv
// Top level of the Bresenham line stepper: ports, frame registers, wiring.
// Depends on bls_pkg, bls_front, bls_fifo, bls_engine and bls_addr.
//
// A load beat (tuser = 0) sets up a line from two signed endpoints and gives
// no result; each step beat (tuser = 1) then yields one pixel with its
// coordinates, a frame clip flag, the address x + y * frame_width (zero when
// outside), its index on the line and the line's step total. tlast marks the
// final pixel; the end point itself is never emitted, so a line gives exactly
// max(|dx|, |dy|) pixels. Steps with no line in progress are dropped. The
// block takes one beat per clock while the result side accepts, as the step
// engine's position and error registers can advance every clock. A step beat
// passes the front register, queue, engine, multiply stage and add and output
// register before its pixel appears. The user must write frame registers only
// while the block is idle; the block itself does not enforce this.
`default_nettype none

module bresenham_line_stepper #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF,
  parameter int FIFO_DEPTH = bls_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Input beats
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // start_x, start_y, end_x, end_y
  input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // action
  input  wire logic                             s_axis_tuser,
  // Result beats
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // pixel_x, pixel_y, inside_res, pixel_address, position_index, total_steps
  output logic [((4*COORD_BITS+bls_pkg::ADDR_W+1+7)/8)*8-1:0] m_axis_tdata,
  // last
  output logic                                  m_axis_tlast,
  // Register writes
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [bls_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [bls_pkg::REG_W-1:0]        cfg_data_i
);

  localparam int C           = COORD_BITS;
  localparam int CMD_W       = bls_pkg::cmd_width(COORD_BITS);
  localparam int OUT_TDATA_W = ((4*COORD_BITS + bls_pkg::ADDR_W + 1 + 7) / 8) * 8;

  logic [bls_pkg::REG_W-1:0]  frame_width_q;
  logic [bls_pkg::REG_W-1:0]  frame_height_q;

  logic                       fq_valid;
  logic                       fq_ready;
  logic [CMD_W-1:0]           fq_data;
  logic                       qe_valid;
  logic                       qe_ready;
  logic [CMD_W-1:0]           qe_data;

  logic                       pix_valid;
  logic                       pix_ready;
  logic [C-1:0]               pix_x;
  logic [C-1:0]               pix_y;
  logic [C-1:0]               pix_index;
  logic [C-1:0]               pix_total;
  logic                       pix_last;

  logic [C-1:0]               pixel_x;
  logic [C-1:0]               pixel_y;
  logic                       inside_res;
  logic [bls_pkg::ADDR_W-1:0] pixel_address;
  logic [C-1:0]               position_index;
  logic [C-1:0]               total_steps;

  // Frame registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= bls_pkg::FRAME_WIDTH_RST;
      frame_height_q <= bls_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (bls_pkg::reg_idx_e'(cfg_index_i))
        bls_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        bls_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bls_front #(
    .COORD_BITS (COORD_BITS),
    .CMD_W      (CMD_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (bls_pkg::action_e'(s_axis_tuser)),
    .start_x_i   (s_axis_tdata[C-1:0]),
    .start_y_i   (s_axis_tdata[2*C-1:C]),
    .end_x_i     (s_axis_tdata[3*C-1:2*C]),
    .end_y_i     (s_axis_tdata[4*C-1:3*C]),
    .cmd_valid_o (fq_valid),
    .cmd_ready_i (fq_ready),
    .cmd_data_o  (fq_data)
  );

  bls_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_data),
    .pop_valid_o  (qe_valid),
    .pop_ready_i  (qe_ready),
    .pop_data_o   (qe_data)
  );

  bls_engine #(
    .COORD_BITS (COORD_BITS),
    .CMD_W      (CMD_W)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (qe_valid),
    .cmd_ready_o (qe_ready),
    .cmd_data_i  (qe_data),
    .pix_valid_o (pix_valid),
    .pix_ready_i (pix_ready),
    .pix_x_o     (pix_x),
    .pix_y_o     (pix_y),
    .pix_index_o (pix_index),
    .pix_total_o (pix_total),
    .pix_last_o  (pix_last)
  );

  bls_addr #(
    .COORD_BITS (COORD_BITS)
  ) u_addr (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .frame_width_i    (frame_width_q),
    .frame_height_i   (frame_height_q),
    .pix_valid_i      (pix_valid),
    .pix_ready_o      (pix_ready),
    .pix_x_i          (pix_x),
    .pix_y_i          (pix_y),
    .pix_index_i      (pix_index),
    .pix_total_i      (pix_total),
    .pix_last_i       (pix_last),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .pixel_x_o        (pixel_x),
    .pixel_y_o        (pixel_y),
    .inside_res_o     (inside_res),
    .pixel_address_o  (pixel_address),
    .position_index_o (position_index),
    .total_steps_o    (total_steps),
    .last_o           (m_axis_tlast)
  );

  // Pack the result beat, first field lowest
  assign m_axis_tdata = OUT_TDATA_W'({total_steps, position_index, pixel_address,
                                      inside_res, pixel_y, pixel_x});

endmodule

`default_nettype wire

FILE: bench/bresenham_line_stepper_tb.sv
// Self-checking testbench for the Bresenham line stepper: endpoint loads, pixel
// steps, frame clipping and address wrap, checked against a built-in line tracer.
// Depends on bls_pkg and bresenham_line_stepper.
module bresenham_line_stepper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW           = bls_pkg::COORD_BITS_DEF;
  localparam int AW           = bls_pkg::ADDR_W;
  localparam int IW           = bls_pkg::CFG_IDX_W;
  localparam int RW           = bls_pkg::REG_W;
  localparam int IN_W         = ((4 * CW + 7) / 8) * 8;
  localparam int OUT_W        = ((4 * CW + AW + 1 + 7) / 8) * 8;
  localparam int DRAIN_CYCLES = 16;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int ITEMS_PER_PHASE = 170;

  // Register indexes past the defined list; writes there must be ignored
  localparam logic [IW-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [IW-1:0] REG_SPARE_HI = 2'd3;

  typedef struct {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          in_frame;
    logic [AW-1:0] addr;
    logic [CW-1:0] index;
    logic [CW-1:0] total;
    logic          last;
  } pixel_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;   // start_x, start_y, end_x, end_y
  logic              s_axis_tuser;   // action
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;   // pixel_x, pixel_y, inside_res, pixel_address,
                                     // position_index, total_steps
  logic              m_axis_tlast;   // last
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [IW-1:0]     cfg_index_i;
  logic [RW-1:0]     cfg_data_i;

  // Line tracer state, mirrors the block
  int             frame_w = 1024;
  int             frame_h = 768;
  bit             ln_active;
  int             ln_cur_x, ln_cur_y, ln_end_x, ln_end_y;
  int             ln_adx, ln_ady, ln_err;
  bit             ln_neg_x, ln_neg_y;
  logic [CW-1:0]  ln_count;
  logic [CW-1:0]  ln_total;

  pixel_t         expected_pixels[$];
  int             error_count;
  int             cycle_count;
  bit             send_idle_en = 1'b1;
  bit             recv_idle_en = 1'b1;
  int             hold_request;
  int             hold_left;

  always #5 clk_i = ~clk_i;

  bresenham_line_stepper i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Count and print one mismatch
  task automatic report_error(string msg);
    error_count++;
    if (error_count <= 50) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Set up a line from packed endpoints
  function automatic void trace_load(logic [IN_W-1:0] ends);
    int sx, sy, ex, ey;
    sx = $signed(ends[CW-1:0]);
    sy = $signed(ends[2*CW-1:CW]);
    ex = $signed(ends[3*CW-1:2*CW]);
    ey = $signed(ends[4*CW-1:3*CW]);
    ln_adx    = (ex > sx) ? ex - sx : sx - ex;
    ln_ady    = (ey > sy) ? ey - sy : sy - ey;
    ln_total  = CW'((ln_adx >= ln_ady) ? ln_adx : ln_ady);
    ln_neg_x  = !(sx < ex);
    ln_neg_y  = !(sy < ey);
    ln_err    = ln_adx - ln_ady;
    ln_cur_x  = sx;
    ln_cur_y  = sy;
    ln_end_x  = ex;
    ln_end_y  = ey;
    ln_count  = '0;
    ln_active = (sx != ex) || (sy != ey);
  endfunction

  // Emit the current pixel and advance; returns 0 when no line is active
  function automatic bit trace_step(output pixel_t px);
    int e2;
    bit in_frame;
    bit fin;
    if (!ln_active) return 1'b0;
    in_frame = ln_cur_x >= 0 && ln_cur_y >= 0 && ln_cur_x < frame_w && ln_cur_y < frame_h;
    px.x        = CW'(ln_cur_x);
    px.y        = CW'(ln_cur_y);
    px.in_frame = in_frame;
    px.addr     = in_frame ? AW'(ln_cur_x + ln_cur_y * frame_w) : '0;
    px.index    = ln_count;
    px.total    = ln_total;
    e2 = ln_err * 2;
    if (e2 > -ln_ady) begin
      ln_err   -= ln_ady;
      ln_cur_x += ln_neg_x ? -1 : 1;
    end
    if (e2 < ln_adx) begin
      ln_err   += ln_adx;
      ln_cur_y += ln_neg_y ? -1 : 1;
    end
    fin     = (ln_cur_x == ln_end_x) && (ln_cur_y == ln_end_y);
    px.last = fin;
    ln_count++;
    if (fin) ln_active = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [IN_W-1:0] pack_ends(int sx, int sy, int ex, int ey);
    return IN_W'({CW'(ey), CW'(ex), CW'(sy), CW'(sx)});
  endfunction

  function automatic int clamp_coord(int v);
    if (v < -(1 << (CW - 1))) return -(1 << (CW - 1));
    if (v > (1 << (CW - 1)) - 1) return (1 << (CW - 1)) - 1;
    return v;
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (!send_idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one beat, wait for acceptance, update the tracer; entered and left at a negedge
  task automatic send_beat(bls_pkg::action_e act, logic [IN_W-1:0] data,
                           output bit made_pixel);
    int gap;
    pixel_t px;
    gap = pick_gap();
    made_pixel = 1'b0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (act == bls_pkg::ACT_LOAD) begin
      trace_load(data);
    end else if (trace_step(px)) begin
      expected_pixels.push_back(px);
      made_pixel = 1'b1;
    end
    @(negedge clk_i);
  endtask

  task automatic load_line(int sx, int sy, int ex, int ey);
    bit unused;
    send_beat(bls_pkg::ACT_LOAD, pack_ends(sx, sy, ex, ey), unused);
  endtask

  // Send step beats with junk endpoint data; count the pixels they make
  task automatic step_pixels(int n, output int produced);
    bit made;
    produced = 0;
    repeat (n) begin
      send_beat(bls_pkg::ACT_STEP, IN_W'({$urandom, $urandom}), made);
      if (made) produced++;
    end
  endtask

  // Hold until every pixel is back and the pipeline has drained
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Write one frame register; call only while idle
  task automatic write_reg(logic [IW-1:0] idx, logic [RW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == bls_pkg::REG_FRAME_WIDTH) frame_w = val;
    else if (idx == bls_pkg::REG_FRAME_HEIGHT) frame_h = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Idle step, degenerate line, both octant directions, clip edges, line replacement
  task automatic test_directed();
    int n;
    step_pixels(1, n);
    load_line(5, 5, 5, 5);
    step_pixels(1, n);
    load_line(0, 0, 3, 1);
    step_pixels(4, n);
    load_line(2047, 2047, 2045, 2043);
    step_pixels(4, n);
    load_line(-2048, -2048, 2047, 2047);
    step_pixels(2, n);
    load_line(-1, 5, 2, 5);
    step_pixels(3, n);
    load_line(1023, 766, 1023, 769);
    step_pixels(3, n);
    wait_idle();
  endtask

  // Tiny, zero and oversized frames, plus writes to unused indexes
  task automatic test_frame_bounds();
    int n;
    write_reg(bls_pkg::REG_FRAME_WIDTH, 12'd1);
    write_reg(bls_pkg::REG_FRAME_HEIGHT, 12'd1);
    write_reg(REG_SPARE_LO, 12'd5);
    write_reg(REG_SPARE_HI, 12'hFFF);
    load_line(-1, -1, 2, 2);
    step_pixels(3, n);
    wait_idle();
    write_reg(bls_pkg::REG_FRAME_WIDTH, 12'd0);
    write_reg(bls_pkg::REG_FRAME_HEIGHT, 12'hFFF);
    load_line(0, 0, 0, 3);
    step_pixels(3, n);
    wait_idle();
    write_reg(bls_pkg::REG_FRAME_WIDTH, 12'hFFF);
    write_reg(bls_pkg::REG_FRAME_HEIGHT, 12'd0);
    load_line(0, 0, 2, 0);
    step_pixels(2, n);
    wait_idle();
    // Address wraps past 2^22 with the widest stride
    write_reg(bls_pkg::REG_FRAME_HEIGHT, 12'hFFF);
    load_line(2000, 1500, 2003, 1500);
    step_pixels(3, n);
    load_line(2047, 2047, 2044, 2046);
    step_pixels(3, n);
    wait_idle();
  endtask

  // Random lines, mostly complete, some cut short or over-stepped, under several frames
  task automatic test_random_lines();
    int done, n, got, r, span, sx, sy, ex, ey;
    bit wild;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(bls_pkg::REG_FRAME_WIDTH, RW'($urandom));
          write_reg(bls_pkg::REG_FRAME_HEIGHT, RW'($urandom));
        end
        1: begin
          write_reg(bls_pkg::REG_FRAME_WIDTH, 12'd64);
          write_reg(bls_pkg::REG_FRAME_HEIGHT, 12'd48);
        end
        2: begin
          write_reg(bls_pkg::REG_FRAME_WIDTH, 12'hFFF);
          write_reg(bls_pkg::REG_FRAME_HEIGHT, 12'hFFF);
        end
        default: begin
          write_reg(bls_pkg::REG_FRAME_WIDTH, bls_pkg::FRAME_WIDTH_RST);
          write_reg(bls_pkg::REG_FRAME_HEIGHT, bls_pkg::FRAME_HEIGHT_RST);
        end
      endcase
      send_idle_en = (ph != 1);
      recv_idle_en = (ph != 2);
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          // stray step, often with no line in progress
          step_pixels(1, got);
          done += got;
        end else begin
          wild = (r < 16);
          if (wild) begin
            sx = int'($urandom_range(0, 4095)) - 2048;
            sy = int'($urandom_range(0, 4095)) - 2048;
            ex = int'($urandom_range(0, 4095)) - 2048;
            ey = int'($urandom_range(0, 4095)) - 2048;
          end else begin
            span = ($urandom_range(0, 9) == 0) ? 60 : 12;
            sx = clamp_coord(int'($urandom_range(0, frame_w + 32)) - 16);
            sy = clamp_coord(int'($urandom_range(0, frame_h + 32)) - 16);
            ex = clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span);
            ey = clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span);
          end
          load_line(sx, sy, ex, ey);
          done++;
          r = $urandom_range(0, 99);
          if (wild) n = $urandom_range(0, 6);
          else if (r < 15) n = $urandom_range(0, ln_total);
          else if (r < 25) n = ln_total + $urandom_range(1, 3);
          else n = ln_total;
          step_pixels(n, got);
          done += got;
        end
      end
      wait_idle();
    end
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
  endtask

  // Receiver holds off for a long stretch while steps keep coming
  task automatic test_backpressure();
    int got;
    send_idle_en = 1'b0;
    hold_request = 400;
    load_line(0, 0, 300, 80);
    step_pixels(150, got);
    send_idle_en = 1'b1;
    step_pixels(150, got);
    wait_idle();
  endtask

  // Result side: random stalls, occasional long ones, forced hold-off on request
  always @(negedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!recv_idle_en) begin
      m_axis_tready <= 1'b1;
    end else if ($urandom_range(0, 99) < 2) begin
      hold_left = $urandom_range(8, 40);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) < 75);
    end
  end

  // Compare each accepted pixel against the oldest expectation
  always @(posedge clk_i) begin : check_pixels
    pixel_t got;
    pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.x        = m_axis_tdata[CW-1:0];
      got.y        = m_axis_tdata[2*CW-1:CW];
      got.in_frame = m_axis_tdata[2*CW];
      got.addr     = m_axis_tdata[2*CW+1 +: AW];
      got.index    = m_axis_tdata[2*CW+1+AW +: CW];
      got.total    = m_axis_tdata[3*CW+1+AW +: CW];
      got.last     = m_axis_tlast;
      if (expected_pixels.size() == 0) begin
        report_error($sformatf("unexpected pixel x=%0h y=%0h", got.x, got.y));
      end else begin
        want = expected_pixels.pop_front();
        if (got.x != want.x)
          report_error($sformatf("pixel_x %0h, want %0h", got.x, want.x));
        if (got.y != want.y)
          report_error($sformatf("pixel_y %0h, want %0h", got.y, want.y));
        if (got.in_frame != want.in_frame)
          report_error($sformatf("inside %0b, want %0b", got.in_frame, want.in_frame));
        if (got.addr != want.addr)
          report_error($sformatf("address %0h, want %0h", got.addr, want.addr));
        if (got.index != want.index)
          report_error($sformatf("index %0d, want %0d", got.index, want.index));
        if (got.total != want.total)
          report_error($sformatf("total %0d, want %0d", got.total, want.total));
        if (got.last != want.last)
          report_error($sformatf("last %0b, want %0b", got.last, want.last));
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = bls_pkg::ACT_LOAD;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = bls_pkg::REG_FRAME_WIDTH;
    cfg_data_i    = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_frame_bounds();
    test_random_lines();
    test_backpressure();

    // Final drain, bounded so leftovers are reported rather than hung on
    s_axis_tvalid <= 1'b0;
    repeat (5000) begin
      if (expected_pixels.size() == 0) break;
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (expected_pixels.size() != 0)
      report_error($sformatf("%0d pixels never arrived", expected_pixels.size()));

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: bresenham_line_stepper.f
src/bls_pkg.sv
src/bls_front.sv
src/bls_fifo.sv
src/bls_engine.sv
src/bls_addr.sv
src/bresenham_line_stepper.sv
bench/bresenham_line_stepper_tb.sv
